// ----- rtl/fpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpfa_pkg
// shared types and constants of the fixed partition fit allocator
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int OPCODE_W = 2;
    localparam int LOAD_IDX_W = 4;
    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;
    localparam int CHOSEN_W = 4;
    localparam int FREE_W = 20;
    localparam int COUNT_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [FREE_W-1:0] TOTAL_MAX = 20'hFFFFF;
    localparam logic [PADDR_W-1:0] REG_COUNT_ADDR = 3'd0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_FIRST = 2'd1,
        OP_BEST  = 2'd2,
        OP_WORST = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC  = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_LOADED = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_FINISH
    } seq_state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic entry_free;
    } scan_ctl_t;

endpackage

// ----- rtl/fpfa_in_if.sv -----
// ----------------------------------------------------------------------------
// fpfa_in_if
// request channel: load or allocate item with valid/ready handshake
// ----------------------------------------------------------------------------
interface fpfa_in_if;
    import fpfa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [AMOUNT_W-1:0]   amount;

    modport source (output valid, output opcode, output load_index, output amount,
                    input ready);
    modport sink   (input valid, input opcode, input load_index, input amount,
                    output ready);
endinterface

// ----- rtl/fpfa_out_if.sv -----
// ----------------------------------------------------------------------------
// fpfa_out_if
// result channel: status, chosen partition and free total
// ----------------------------------------------------------------------------
interface fpfa_out_if;
    import fpfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHOSEN_W-1:0] chosen_index;
    logic [FREE_W-1:0]   free_total;

    modport source (output valid, output status, output chosen_index, output free_total,
                    input ready);
    modport sink   (input valid, input status, input chosen_index, input free_total,
                    output ready);
endinterface

// ----- rtl/fpfa_fit_scan.sv -----
// ----------------------------------------------------------------------------
// fpfa_fit_scan
// shared fit compare unit: one partition per step, tracks the chosen entry,
// its leftover and the running sum of free sizes
// ----------------------------------------------------------------------------
module fpfa_fit_scan #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4,
    parameter int SUM_W     = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fpfa_pkg::scan_ctl_t          ctl,
    input  logic [fpfa_pkg::OPCODE_W-1:0] policy,
    input  logic [fpfa_pkg::AMOUNT_W-1:0] req,
    input  logic [SIZE_BITS-1:0]         entry_size,
    input  logic [IDX_W-1:0]             entry_idx,
    output logic                         found,
    output logic [IDX_W-1:0]             chosen,
    output logic [SIZE_BITS-1:0]         chosen_size,
    output logic [SUM_W-1:0]             free_sum
);
    import fpfa_pkg::*;

    localparam int CW = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    logic                 found_reg;
    logic                 found_next;
    logic [CW-1:0]        keep_reg;
    logic [IDX_W-1:0]     chosen_reg;
    logic [SIZE_BITS-1:0] chosen_size_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CW-1:0]        size_ext;
    logic [CW-1:0]        req_ext;
    logic [CW-1:0]        left;
    logic                 fits;
    logic                 better;
    logic                 take;

    always_comb
    begin
        size_ext   = CW'(entry_size);
        req_ext    = CW'(req);
        fits       = ctl.entry_free && (size_ext >= req_ext);
        left       = size_ext - req_ext;
        better     = !found_reg
                     || ((policy == OP_BEST) && (left < keep_reg))
                     || ((policy == OP_WORST) && (left > keep_reg));
        take       = ctl.step && fits && better;
        found_next = ctl.clear ? 1'b0 : (found_reg || take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            sum_reg <= '0;
        end
        else if (ctl.step && ctl.entry_free)
        begin
            sum_reg <= sum_reg + SUM_W'(entry_size);
        end
        if (take)
        begin
            keep_reg        <= left;
            chosen_reg      <= entry_idx;
            chosen_size_reg <= entry_size;
        end
    end

    assign found       = found_reg;
    assign chosen      = chosen_reg;
    assign chosen_size = chosen_size_reg;
    assign free_sum    = sum_reg;

endmodule

// ----- rtl/fixed_partition_fit_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top
// fixed-partition allocator with first, best and worst fit over a size table
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      opcode, load_index, amount
//   out_ch    out   valid/ready      status, chosen_index, free_total
//   apb       in    psel/penable     partition_count at byte address 0
//
// an item scans n = min(partition_count, MAX_PARTS) table entries, a load after
// writing its entry; the scan reads one table entry per cycle through the
// registered read port of the size memory
// one item at a time: in_ch.ready is high only while the sequencer is idle
// a waiting result does not block the next transfer, only the next result
// reset clears sizes (through per-entry valid bits), allocated marks and count
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_top #(
    parameter int MAX_PARTS = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    fpfa_in_if.sink                          in_ch,
    fpfa_out_if.source                       out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fpfa_pkg::PADDR_W-1:0]     paddr,
    input  logic [fpfa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fpfa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import fpfa_pkg::*;

    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int N_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W = SIZE_BITS + CNT_W;
    localparam int TW    = (SUM_W > FREE_W) ? SUM_W : FREE_W;

    // configuration
    logic [COUNT_W-1:0] count_reg;
    logic               cfg_wr;
    logic [N_W-1:0]     n_use;

    // sequencer
    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [LOAD_IDX_W-1:0] idx_reg;
    logic [AMOUNT_W-1:0] amt_reg;
    logic [N_W-1:0]      scan_cnt_reg;
    logic [N_W-1:0]      scan_cnt_next;
    logic                rd_pend_reg;
    logic                rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_free_reg;
    logic                rd_sv_reg;
    logic                accept;
    logic                is_load;
    logic                load_ok;
    logic                wr_en;
    logic                rd_en;
    logic                finish_fire;
    logic                mark_en;
    logic [IDX_W-1:0]    scan_addr;
    logic [IDX_W-1:0]    load_addr;

    // storage
    logic [SIZE_BITS-1:0] size_mem [MAX_PARTS];
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic [MAX_PARTS-1:0] size_vld_reg;
    logic [MAX_PARTS-1:0] taken_reg;

    // fit unit
    scan_ctl_t            scan_ctl;
    logic                 found;
    logic [IDX_W-1:0]     chosen;
    logic [SIZE_BITS-1:0] chosen_size;
    logic [SUM_W-1:0]     free_sum;
    logic [SIZE_BITS-1:0] entry_size;

    // result
    logic [SUM_W-1:0]    total_raw;
    logic [TW-1:0]       total_ext;
    logic [FREE_W-1:0]   total_sat;
    status_t             status_new;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CHOSEN_W-1:0] chosen_out_reg;
    logic [FREE_W-1:0]   free_total_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_COUNT_ADDR);
    assign prdata = (paddr == REG_COUNT_ADDR) ? APB_DATA_W'(count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        if (N_W'(count_reg) > N_W'(MAX_PARTS))
        begin
            n_use = N_W'(MAX_PARTS);
        end
        else
        begin
            n_use = N_W'(count_reg);
        end
    end

    // sequencer
    assign accept    = in_ch.valid && in_ch.ready;
    assign is_load   = (op_reg == OP_LOAD);
    assign load_ok   = N_W'(idx_reg) < n_use;
    assign load_addr = IDX_W'(idx_reg);
    assign scan_addr = scan_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_pend_next  = 1'b0;
        in_ch.ready   = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        finish_fire   = 1'b0;
        scan_ctl.clear      = 1'b0;
        scan_ctl.step       = rd_pend_reg;
        scan_ctl.entry_free = rd_free_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    scan_ctl.clear = 1'b1;
                    scan_cnt_next  = '0;
                    state_next     = (in_ch.opcode == OP_LOAD) ? S_WRITE : S_SCAN;
                end
            end
            S_WRITE:
            begin
                wr_en      = load_ok;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_cnt_reg < n_use)
                begin
                    rd_en         = 1'b1;
                    rd_pend_next  = 1'b1;
                    scan_cnt_next = scan_cnt_reg + N_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    finish_fire = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_ch.opcode;
            idx_reg <= in_ch.load_index;
            amt_reg <= in_ch.amount;
        end
        if (rd_en)
        begin
            rd_idx_reg  <= scan_addr;
            rd_free_reg <= !taken_reg[scan_addr];
            rd_sv_reg   <= size_vld_reg[scan_addr];
        end
    end

    // size memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[load_addr] <= SIZE_BITS'(amt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= size_mem[scan_addr];
        end
    end

    // valid bits and allocated marks
    assign mark_en = finish_fire && !is_load && found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_vld_reg <= '0;
            taken_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                size_vld_reg[load_addr] <= 1'b1;
                taken_reg[load_addr]    <= 1'b0;
            end
            if (mark_en)
            begin
                taken_reg[chosen] <= 1'b1;
            end
        end
    end

    // shared fit unit
    assign entry_size = rd_sv_reg ? rd_data_reg : '0;

    fpfa_fit_scan #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .SUM_W     (SUM_W)
    ) u_fit_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .policy      (op_reg),
        .req         (amt_reg),
        .entry_size  (entry_size),
        .entry_idx   (rd_idx_reg),
        .found       (found),
        .chosen      (chosen),
        .chosen_size (chosen_size),
        .free_sum    (free_sum)
    );

    // result
    always_comb
    begin
        if (!is_load && found)
        begin
            total_raw = free_sum - SUM_W'(chosen_size);
        end
        else
        begin
            total_raw = free_sum;
        end
        total_ext = TW'(total_raw);
        if (total_ext > TW'(TOTAL_MAX))
        begin
            total_sat = TOTAL_MAX;
        end
        else
        begin
            total_sat = FREE_W'(total_ext);
        end
        if (is_load)
        begin
            status_new = load_ok ? ST_LOADED : ST_RANGE;
        end
        else
        begin
            status_new = found ? ST_ALLOC : ST_NOFIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            status_reg     <= status_new;
            chosen_out_reg <= (status_new == ST_ALLOC) ? CHOSEN_W'(chosen) : '0;
            free_total_reg <= total_sat;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.chosen_index = chosen_out_reg;
    assign out_ch.free_total   = free_total_reg;

    // checks
    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status != ST_ALLOC)) |-> (out_ch.chosen_index == '0))
        else $error("chosen index not zero on a non-allocate result");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= n_use))
        else $error("scan counter ran past the partitions in use");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after an input transfer");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_SCAN))
        else $error("table read pending outside the scan");

    a_mark_set: assert property (@(posedge clk) disable iff (!rst_n)
        mark_en |=> taken_reg[$past(chosen)])
        else $error("allocated partition not marked");

endmodule

// ----- bench/fixed_partition_fit_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top_tb
// self-checking bench for the fixed partition fit allocator
//
// a short table of directed items and count writes runs first, then several
// phases of random loads and first, best and worst fit requests, each phase
// under its own partition count; every accepted item is run through a local
// model of the size table and allocated marks, and every result transfer is
// compared field by field with the oldest pending answer; both channels idle
// in random bursts, the result side holds off once for a long stretch, and
// the last phase runs without gaps
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_top_tb;
    import fpfa_pkg::*;

    localparam int PARTS = 16;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 62;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PLAN_ROWS = 25;

    typedef struct packed {
        logic                  set_count;
        logic [COUNT_W-1:0]    count;
        opcode_t               op;
        logic [LOAD_IDX_W-1:0] idx;
        logic [AMOUNT_W-1:0]   amt;
        logic                  typed;
        status_t               st;
        logic [CHOSEN_W-1:0]   chosen;
        logic [FREE_W-1:0]     free;
    } plan_row_t;

    typedef struct packed {
        status_t             status;
        logic [CHOSEN_W-1:0] chosen;
        logic [FREE_W-1:0]   free;
    } answer_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{1'b0, 5'd0,  OP_FIRST, 4'd0,  16'd0,     1'b1, ST_NOFIT,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd0,  16'd5,     1'b1, ST_RANGE,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_WORST, 4'd7,  16'hFFFF,  1'b1, ST_NOFIT,  4'd0, 20'd0},
        '{1'b1, 5'd16, OP_LOAD,  4'd0,  16'd0,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd15, 16'hFFFF,  1'b1, ST_LOADED, 4'd0, 20'd65535},
        '{1'b0, 5'd0,  OP_LOAD,  4'd0,  16'd0,     1'b1, ST_LOADED, 4'd0, 20'd65535},
        '{1'b0, 5'd0,  OP_FIRST, 4'd9,  16'd0,     1'b1, ST_ALLOC,  4'd0, 20'd65535},
        '{1'b0, 5'd0,  OP_LOAD,  4'd1,  16'd100,   1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd2,  16'd50,    1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd3,  16'd100,   1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd4,  16'd50,    1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_BEST,  4'd0,  16'd50,    1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_WORST, 4'd0,  16'd10,    1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_WORST, 4'd0,  16'd10,    1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_FIRST, 4'd15, 16'hFFFF,  1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_BEST,  4'd0,  16'd0,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b1, 5'd31, OP_LOAD,  4'd0,  16'd0,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd15, 16'h5555,  1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_FIRST, 4'd0,  16'd1,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b1, 5'd3,  OP_LOAD,  4'd0,  16'd0,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd3,  16'd1,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd15, 16'hAAAA,  1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_WORST, 4'd0,  16'd0,     1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_LOAD,  4'd2,  16'hFFFF,  1'b0, ST_ALLOC,  4'd0, 20'd0},
        '{1'b0, 5'd0,  OP_BEST,  4'd0,  16'd1,     1'b0, ST_ALLOC,  4'd0, 20'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    fpfa_in_if  in_ch ();
    fpfa_out_if out_ch ();

    fixed_partition_fit_allocator_top #(
        .MAX_PARTS (PARTS),
        .SIZE_BITS (AMOUNT_W)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the partition table
    logic [AMOUNT_W-1:0] part_len [PARTS];
    logic                part_used [PARTS];
    logic [COUNT_W-1:0]  live_count;

    answer_t pending_answers[$];
    answer_t oldest;
    int      failures;
    int      cycles;
    int      items_sent;
    int      count_writes;
    int      seen_alloc;
    int      seen_nofit;
    int      seen_loaded;
    int      seen_range;
    bit      calm;
    bit      hold_off_req;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int parts_in_use();
        return (live_count > PARTS) ? PARTS : int'(live_count);
    endfunction

    function automatic answer_t apply_request(input opcode_t op,
                                              input logic [LOAD_IDX_W-1:0] idx,
                                              input logic [AMOUNT_W-1:0] amt);
        answer_t             ans;
        int                  n;
        int                  pick;
        int                  i;
        longint              sum;
        logic [AMOUNT_W-1:0] keep;
        logic [AMOUNT_W-1:0] left;
        n = parts_in_use();
        pick = -1;
        keep = '0;
        ans.chosen = '0;
        if (op == OP_LOAD)
        begin
            if (int'(idx) < n)
            begin
                part_len[idx] = amt;
                part_used[idx] = 1'b0;
                ans.status = ST_LOADED;
            end
            else
            begin
                ans.status = ST_RANGE;
            end
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                if (!part_used[i] && part_len[i] >= amt)
                begin
                    left = part_len[i] - amt;
                    if (pick < 0 || (op == OP_BEST && left < keep) ||
                        (op == OP_WORST && left > keep))
                    begin
                        pick = i;
                        keep = left;
                    end
                end
            end
            if (pick >= 0)
            begin
                part_used[pick] = 1'b1;
                ans.chosen = pick[CHOSEN_W-1:0];
                ans.status = ST_ALLOC;
            end
            else
            begin
                ans.status = ST_NOFIT;
            end
        end
        sum = 0;
        for (i = 0; i < n; i++)
        begin
            if (!part_used[i])
                sum += part_len[i];
        end
        ans.free = (sum > longint'(TOTAL_MAX)) ? TOTAL_MAX : sum[FREE_W-1:0];
        return ans;
    endfunction

    task automatic pause_sender(input int n);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic issue(input opcode_t op, input logic [LOAD_IDX_W-1:0] idx,
                         input logic [AMOUNT_W-1:0] amt, input bit typed,
                         input answer_t typed_ans);
        answer_t ans;
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.opcode = op;
        in_ch.load_index = idx;
        in_ch.amount = amt;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        ans = apply_request(op, idx, amt);
        pending_answers.push_back(typed ? typed_ans : ans);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 18));
    endtask

    // config writes only once the block has drained
    task automatic write_count(input logic [COUNT_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[COUNT_W-1:0] = value;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = REG_COUNT_ADDR;
        pwdata = word;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        live_count = value;
        count_writes++;
    endtask

    // result side: random stalls and one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result transfer: status %0d chosen_index %0d free_total %0d",
                       out_ch.status, out_ch.chosen_index, out_ch.free_total);
                failures++;
            end
            else
            begin
                oldest = pending_answers.pop_front();
                if (out_ch.status !== oldest.status)
                begin
                    $error("status: expected %0d, got %0d", oldest.status, out_ch.status);
                    failures++;
                end
                if (out_ch.chosen_index !== oldest.chosen)
                begin
                    $error("chosen_index: expected %0d, got %0d",
                           oldest.chosen, out_ch.chosen_index);
                    failures++;
                end
                if (out_ch.free_total !== oldest.free)
                begin
                    $error("free_total: expected %0d, got %0d",
                           oldest.free, out_ch.free_total);
                    failures++;
                end
                case (oldest.status)
                    ST_ALLOC:  seen_alloc++;
                    ST_NOFIT:  seen_nofit++;
                    ST_LOADED: seen_loaded++;
                    default:   seen_range++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int                    row;
        int                    phase;
        int                    k;
        int                    n;
        int                    r;
        logic [COUNT_W-1:0]    cnt;
        opcode_t               op;
        logic [LOAD_IDX_W-1:0] idx;
        logic [AMOUNT_W-1:0]   amt;
        answer_t               typed_ans;
        failures = 0;
        cycles = 0;
        items_sent = 0;
        count_writes = 0;
        seen_alloc = 0;
        seen_nofit = 0;
        seen_loaded = 0;
        seen_range = 0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        live_count = '0;
        for (k = 0; k < PARTS; k++)
        begin
            part_len[k] = '0;
            part_used[k] = 1'b0;
        end
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_LOAD;
        in_ch.load_index = '0;
        in_ch.amount = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (row = 0; row < PLAN_ROWS; row++)
        begin
            if (PLAN[row].set_count)
            begin
                write_count(PLAN[row].count);
            end
            else
            begin
                typed_ans.status = PLAN[row].st;
                typed_ans.chosen = PLAN[row].chosen;
                typed_ans.free = PLAN[row].free;
                issue(PLAN[row].op, PLAN[row].idx, PLAN[row].amt, PLAN[row].typed, typed_ans);
            end
        end

        // random phases, one partition count each
        typed_ans = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       cnt = 5'd16;
                1:       cnt = 5'd0;
                2:       cnt = 5'd31;
                3:       cnt = 5'd1;
                8:       cnt = 5'd16;
                default: cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                            : 5'($urandom_range(2, 16));
            endcase
            write_count(cnt);
            if (phase == PHASES - 1)
                calm = 1'b1;
            n = parts_in_use();
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 5 && k == 8)
                    hold_off_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    op = OP_LOAD;
                    if (n > 0 && $urandom_range(0, 9) < 8)
                        idx = LOAD_IDX_W'($urandom_range(0, n - 1));
                    else
                        idx = LOAD_IDX_W'($urandom_range(0, 15));
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        amt = '0;
                    else if (r == 1)
                        amt = '1;
                    else if (r < 6)
                        amt = AMOUNT_W'($urandom_range(0, 255));
                    else
                        amt = AMOUNT_W'($urandom);
                end
                else
                begin
                    op = opcode_t'($urandom_range(1, 3));
                    idx = LOAD_IDX_W'($urandom);
                    r = $urandom_range(0, 9);
                    if (r < 4 && n > 0)
                        amt = part_len[$urandom_range(0, n - 1)] -
                              AMOUNT_W'($urandom_range(0, 3));
                    else if (r < 6)
                        amt = AMOUNT_W'($urandom_range(0, 300));
                    else if (r == 6)
                        amt = '0;
                    else if (r == 7)
                        amt = '1;
                    else
                        amt = AMOUNT_W'($urandom);
                end
                issue(op, idx, amt, 1'b0, typed_ans);
            end
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("items %0d over %0d count settings; results: %0d allocated, %0d no fit,",
                 items_sent, count_writes, seen_alloc, seen_nofit);
        $display("  %0d loads accepted, %0d loads out of range", seen_loaded, seen_range);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fpfa_pkg.sv
rtl/fpfa_in_if.sv
rtl/fpfa_out_if.sv
rtl/fpfa_fit_scan.sv
rtl/fixed_partition_fit_allocator_top.sv
bench/fixed_partition_fit_allocator_top_tb.sv
